FILE: sv/pfmt_pkg.sv
// Shared constants, codes and types for the padded integer formatter.
package pfmt_pkg;

    // Value and counter widths.
    localparam int VALUE_BITS  = 32;
    localparam int DIGIT_SLOTS = 32;
    localparam int DIG_IDX_W   = 5;
    localparam int CNT_W       = 6;

    // Reciprocal of ten: floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for 32-bit x.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Radix selector codes.
    localparam logic [2:0] RADIX_DEC    = 3'd0;
    localparam logic [2:0] RADIX_HEX_LO = 3'd1;
    localparam logic [2:0] RADIX_HEX_UP = 3'd2;
    localparam logic [2:0] RADIX_OCT    = 3'd3;
    localparam logic [2:0] RADIX_BIN    = 3'd4;

    // ASCII characters.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One step of digit extraction: the quotient and the digit that falls out.
    typedef struct packed {
        logic [VALUE_BITS-1:0] quot;
        logic [3:0]            rem;
    } t_digit_res;

endpackage

FILE: sv/pfmt_digit_unit.sv
// Shared digit extraction unit: one division of the magnitude by the radix.
module pfmt_digit_unit
    import pfmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [VALUE_BITS-1:0] i_mag,
    input  logic [2:0]            i_radix_sel,
    output t_digit_res            o_res
);

    logic [2*VALUE_BITS-1:0] r_prod;
    logic [VALUE_BITS-1:0]   r_mag;
    logic [2:0]              r_sel;
    logic [VALUE_BITS-1:0]   dec_q;
    logic [VALUE_BITS-1:0]   dec_r;

    // Register the operand and its product with the reciprocal of ten.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= {{VALUE_BITS{1'b0}}, i_mag} * {{VALUE_BITS{1'b0}}, RECIP_10};
            r_mag  <= i_mag;
            r_sel  <= i_radix_sel;
        end
    end

    // Decimal quotient from the product; the remainder is the operand minus ten times it.
    assign dec_q = {{RECIP_SHIFT-VALUE_BITS{1'b0}}, r_prod[2*VALUE_BITS-1:RECIP_SHIFT]};
    assign dec_r = r_mag - {dec_q[VALUE_BITS-4:0], 3'b000} - {dec_q[VALUE_BITS-2:0], 1'b0};

    // Power-of-two radices are plain shifts and masks.
    always_comb begin
        case (r_sel)
            RADIX_HEX_LO, RADIX_HEX_UP: begin
                o_res.quot = {4'b0000, r_mag[VALUE_BITS-1:4]};
                o_res.rem  = r_mag[3:0];
            end
            RADIX_OCT: begin
                o_res.quot = {3'b000, r_mag[VALUE_BITS-1:3]};
                o_res.rem  = {1'b0, r_mag[2:0]};
            end
            RADIX_BIN: begin
                o_res.quot = {1'b0, r_mag[VALUE_BITS-1:1]};
                o_res.rem  = {3'b000, r_mag[0]};
            end
            default: begin
                o_res.quot = dec_q;
                o_res.rem  = dec_r[3:0];
            end
        endcase
    end

endmodule

FILE: sv/padded_integer_formatter_unit.sv
// Top level of the padded integer formatter: sequencer, digit store and character output.
//
// Usage: drive i_value, i_radix_sel, i_pad_char and i_field_width and raise start
// while busy is low; the transaction is taken at that clock edge and busy rises.
// The block then works out the magnitude's digits, least significant first, by
// repeated division in one shared digit unit: for each digit the S_MUL state forms
// the product with the reciprocal of ten and the S_DIGIT state takes quotient and
// remainder, for every radix. Decimal needs up to 10 digits, binary up to 32.
// It then emits the text one character per cycle: sign, padding and digits in
// the order the pad character calls for, at least the field width in total.
// Each character appears on o_ch for exactly one cycle with o_valid high, the
// final one with o_last high. The receiver cannot stall; characters are registered
// and shown in the cycle after the sequencer produces them and are never held.
// Busy falls in the same cycle as the last character appears on o_ch.
// Radix codes five to seven format in decimal; a zero value prints one digit.
// Synchronous reset returns the sequencer to idle and clears o_valid.
module padded_integer_formatter_unit
    import pfmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [2:0]            i_radix_sel,
    input  logic [7:0]            i_pad_char,
    input  logic [5:0]            i_field_width,
    output logic                  o_valid,
    output logic [7:0]            o_ch,
    output logic                  o_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MUL   = 2'd1;
    localparam logic [1:0] S_DIGIT = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [2:0]            r_sel;
    logic [7:0]            r_pad;
    logic [5:0]            r_width;
    logic [CNT_W-1:0]      r_nd;
    logic [CNT_W-1:0]      r_rd;
    logic [CNT_W-1:0]      r_pos;
    logic [3:0]            r_digits [DIGIT_SLOTS];
    logic                  r_out_valid;
    logic [7:0]            r_out_ch;
    logic                  r_out_last;

    logic                  accept;
    logic [VALUE_BITS-1:0] in_mag;
    t_digit_res            dres;
    logic [CNT_W-1:0]      content;
    logic [CNT_W-1:0]      pads;
    logic [CNT_W-1:0]      total;
    logic [CNT_W-1:0]      sign_pos;
    logic [CNT_W-1:0]      first_digit;
    logic [CNT_W-1:0]      rd_idx;
    logic [3:0]            cur_digit;
    logic                  space_pad;
    logic                  upper;
    logic                  is_sign;
    logic                  is_pad;
    logic                  is_last;
    logic [7:0]            digit_ch;
    logic [7:0]            emit_ch;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign in_mag = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    pfmt_digit_unit u_digit (
        .i_clk       (i_clk),
        .i_load      (r_state == S_MUL),
        .i_mag       (r_mag),
        .i_radix_sel (r_sel),
        .o_res       (dres)
    );

    // Field layout: sign position, pad run and where the digits begin.
    assign space_pad   = (r_pad == CH_SPACE);
    assign upper       = (r_sel == RADIX_HEX_UP);
    assign content     = r_nd + {{CNT_W-1{1'b0}}, r_neg};
    assign pads        = (r_width > content) ? (r_width - content) : '0;
    assign total       = (r_width > content) ? r_width : content;
    assign sign_pos    = space_pad ? pads : '0;
    assign first_digit = pads + {{CNT_W-1{1'b0}}, r_neg};
    assign rd_idx      = r_rd - 1'b1;
    assign cur_digit   = r_digits[rd_idx[DIG_IDX_W-1:0]];

    // Character selection for the current output position.
    always_comb begin
        is_sign = r_neg && (r_pos == sign_pos);
        is_pad  = !is_sign && (r_pos < first_digit);
        is_last = (r_pos == total - 1'b1);
        if (cur_digit < 4'd10) begin
            digit_ch = CH_ZERO + {4'b0000, cur_digit};
        end else begin
            digit_ch = (upper ? CH_UPPER : CH_LOWER) + {4'b0000, cur_digit} - 8'd10;
        end
        if (is_sign) begin
            emit_ch = CH_MINUS;
        end else if (is_pad) begin
            emit_ch = r_pad;
        end else begin
            emit_ch = digit_ch;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIGIT;
            end
            S_DIGIT: begin
                n_state = (dres.quot == '0) ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (is_last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_EMIT);
        end
    end

    // Transaction fields, digit counting and output position.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag   <= in_mag;
            r_neg   <= i_value[VALUE_BITS-1];
            r_sel   <= i_radix_sel;
            r_pad   <= i_pad_char;
            r_width <= i_field_width;
            r_nd    <= '0;
            r_pos   <= '0;
        end else if (r_state == S_DIGIT) begin
            r_mag  <= dres.quot;
            r_nd   <= r_nd + 1'b1;
            r_rd   <= r_nd + 1'b1;
        end else if (r_state == S_EMIT) begin
            r_pos <= r_pos + 1'b1;
            if (!is_sign && !is_pad) begin
                r_rd <= rd_idx;
            end
        end
    end

    // Digit store, least significant digit at slot zero.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIGIT) begin
            r_digits[r_nd[DIG_IDX_W-1:0]] <= dres.rem;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_out_ch   <= emit_ch;
            r_out_last <= is_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_ch    = r_out_ch;
    assign o_last  = r_out_valid && r_out_last;

    // A character strobe only follows a cycle of emitting.
    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_EMIT)
        else $error("character strobe without emit cycle");

    // An accepted transaction makes the block busy.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy did not rise after accepted transaction");

    // The digit count never passes the store depth.
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> r_nd < CNT_W'(DIGIT_SLOTS))
        else $error("digit store overflow");

    // Digits are read only while some remain.
    a_digit_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !is_sign && !is_pad) |-> r_rd != '0)
        else $error("digit read with none remaining");

endmodule

FILE: dv/padded_integer_formatter_unit_tb.sv
// Self-checking testbench for the padded integer formatter: directed cases, then random numbers.
module padded_integer_formatter_unit_tb
    import pfmt_pkg::*;
();

    // One formatted character as it should leave the block.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    localparam int CYCLE_LIMIT = 500000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic [VALUE_BITS-1:0] i_value       = '0;
    logic [2:0]            i_radix_sel   = RADIX_DEC;
    logic [7:0]            i_pad_char    = CH_SPACE;
    logic [5:0]            i_field_width = '0;
    logic                  busy;
    logic                  o_valid;
    logic [7:0]            o_ch;
    logic                  o_last;

    t_text_char expected_text[$];
    int         mismatch_count = 0;
    int         numbers_sent   = 0;
    int         chars_checked  = 0;
    int         cycle_count    = 0;

    padded_integer_formatter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_radix_sel   (i_radix_sel),
        .i_pad_char    (i_pad_char),
        .i_field_width (i_field_width),
        .o_valid       (o_valid),
        .o_ch          (o_ch),
        .o_last        (o_last)
    );

    // Free-running clock with a period of two time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d characters still expected",
                     cycle_count, expected_text.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Print one mismatch and count it.
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("Mismatch at cycle %0d: %s got 0x%02h expected 0x%02h",
                 cycle_count, what, got, want);
    endtask

    // Work out the character run for one number and queue it.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value,
                                         input logic [2:0] radix, input logic [7:0] pad,
                                         input logic [5:0] width);
        logic                  negative;
        logic [VALUE_BITS-1:0] magnitude;
        logic [VALUE_BITS-1:0] base;
        logic [VALUE_BITS-1:0] digit;
        logic                  upper;
        logic [7:0]            digits[VALUE_BITS];
        int                    n_digits;
        int                    n_pads;
        t_text_char            run[$];
        t_text_char            c;

        negative  = value[VALUE_BITS-1];
        magnitude = negative ? -value : value;
        upper     = 1'b0;
        case (radix)
            RADIX_HEX_LO: base = 16;
            RADIX_HEX_UP: begin
                base  = 16;
                upper = 1'b1;
            end
            RADIX_OCT: base = 8;
            RADIX_BIN: base = 2;
            default:   base = 10;
        endcase

        // Digits come out least significant first; zero still gives one digit.
        n_digits = 0;
        do begin
            digit     = magnitude % base;
            magnitude = magnitude / base;
            if (digit < 10)
                digits[n_digits] = CH_ZERO + digit[7:0];
            else
                digits[n_digits] = (upper ? CH_UPPER : CH_LOWER) + digit[7:0] - 8'd10;
            n_digits++;
        end while (magnitude != 0);

        n_pads = int'(width) - n_digits - (negative ? 1 : 0);
        c.last = 1'b0;
        // The sign leads the padding unless the pad is a space.
        if (negative && pad != CH_SPACE) begin
            c.ch = CH_MINUS;
            run.push_back(c);
        end
        for (int k = 0; k < n_pads; k++) begin
            c.ch = pad;
            run.push_back(c);
        end
        if (negative && pad == CH_SPACE) begin
            c.ch = CH_MINUS;
            run.push_back(c);
        end
        for (int k = n_digits - 1; k >= 0; k--) begin
            c.ch = digits[k];
            run.push_back(c);
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[k])
            expected_text.push_back(run[k]);
    endfunction

    // Present one number and hold start until the block takes it.
    task automatic send_number(input logic [VALUE_BITS-1:0] value, input logic [2:0] radix,
                               input logic [7:0] pad, input logic [5:0] width);
        i_value       <= value;
        i_radix_sel   <= radix;
        i_pad_char    <= pad;
        i_field_width <= width;
        start         <= 1'b1;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        predict_text(value, radix, pad, width);
        numbers_sent++;
    endtask

    // Sometimes drop start for a while; long gaps land on any phase of the work.
    task automatic sender_gap(input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 140)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every queued character has been seen.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Compare each character leaving the block with the oldest expected one.
    always @(negedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid) begin
            if (expected_text.size() == 0) begin
                report_mismatch("unexpected character", o_ch, 8'h00);
            end else begin
                want = expected_text.pop_front();
                chars_checked++;
                if (o_ch !== want.ch)
                    report_mismatch("character", o_ch, want.ch);
                if (o_last !== want.last)
                    report_mismatch("last flag", {7'd0, o_last}, {7'd0, want.last});
            end
        end
    end

    // Extreme values in every radix, including the most negative number.
    task automatic test_value_extremes();
        send_number(32'd0, RADIX_DEC, CH_ZERO, 6'd0);
        send_number(32'h8000_0000, RADIX_DEC, CH_SPACE, 6'd15);
        send_number(32'h7FFF_FFFF, RADIX_DEC, 8'h2A, 6'd0);
        send_number(32'h8000_0000, RADIX_HEX_LO, CH_ZERO, 6'd0);
        send_number(32'h8000_0000, RADIX_HEX_UP, 8'h2A, 6'd12);
        send_number(32'h8000_0000, RADIX_OCT, CH_ZERO, 6'd0);
        send_number(32'h8000_0000, RADIX_BIN, CH_SPACE, 6'd63);
        send_number(32'hFFFF_FFFF, RADIX_BIN, 8'h00, 6'd63);
        send_number(32'h7FFF_FFFF, RADIX_BIN, 8'hFF, 6'd33);
        send_number(32'd0, RADIX_HEX_UP, CH_SPACE, 6'd63);
    endtask

    // Letter case in hex and the unused radix codes that fall back to decimal.
    task automatic test_radix_codes();
        send_number(32'h7ABC_DEF0, RADIX_HEX_LO, CH_ZERO, 6'd10);
        send_number(32'h7ABC_DEF0, RADIX_HEX_UP, CH_ZERO, 6'd10);
        send_number(-32'sd12345, 3'd5, CH_ZERO, 6'd8);
        send_number(-32'sd12345, 3'd6, CH_SPACE, 6'd8);
        send_number(32'd98765, 3'd7, 8'h55, 6'd2);
        send_number(32'd255, RADIX_OCT, 8'hAA, 6'd63);
    endtask

    // Sign placement against space and non-space pads, and exact-fit widths.
    task automatic test_sign_and_padding();
        send_number(-32'sd42, RADIX_DEC, CH_SPACE, 6'd8);
        send_number(-32'sd42, RADIX_DEC, CH_ZERO, 6'd8);
        send_number(-32'sd42, RADIX_DEC, 8'hFF, 6'd1);
        send_number(-32'sd42, RADIX_DEC, 8'h00, 6'd3);
        send_number(32'd1, RADIX_BIN, CH_ZERO, 6'd1);
        send_number(-32'sd1, RADIX_HEX_LO, CH_SPACE, 6'd2);
    endtask

    // Random magnitude classes so short and long texts both show up often.
    function automatic logic [VALUE_BITS-1:0] random_value();
        case ($urandom_range(5))
            0: return $urandom_range(600) - 300;
            1: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                        : 32'h7FFF_FFFF - $urandom_range(3);
            2: return (32'd1 << $urandom_range(31)) * ($urandom_range(1) ? 32'd1 : -32'sd1);
            default: return $urandom;
        endcase
    endfunction

    // Random numbers, radix codes, pads and widths with the given sender idling.
    task automatic test_random_numbers(input int count, input int idle_pct);
        logic [7:0] pad;
        logic [2:0] radix;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0:       pad = CH_SPACE;
                1:       pad = CH_ZERO;
                default: pad = 8'($urandom_range(255));
            endcase
            if ($urandom_range(9) == 0)
                radix = 3'($urandom_range(5, 7));
            else
                radix = 3'($urandom_range(4));
            send_number(random_value(), radix, pad, 6'($urandom_range(63)));
            sender_gap(idle_pct);
        end
    endtask

    // The sender holds off until the block has emitted everything, then resumes.
    task automatic test_pause_for_drain();
        test_random_numbers(3, 0);
        wait_for_drain();
        test_random_numbers(3, 0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_value_extremes();
        test_radix_codes();
        test_sign_and_padding();
        test_random_numbers(80, 11);
        test_pause_for_drain();
        test_random_numbers(75, 79);
        test_random_numbers(70, 0);

        wait_for_drain();
        repeat (140) @(posedge i_clk);
        foreach (expected_text[k])
            report_mismatch("missing character", 8'h00, expected_text[k].ch);

        $display("Formatted %0d numbers in all radix codes with space, zero and other pads;",
                 numbers_sent);
        $display("%0d characters checked, %0d mismatches.", chars_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/pfmt_pkg.sv
sv/pfmt_digit_unit.sv
sv/padded_integer_formatter_unit.sv
dv/padded_integer_formatter_unit_tb.sv
